FILE: hw/rtl/rrtr_pkg.sv
// Shared types and constants for the round-robin thread ring.
// Holds action codes, controller states and the control/status structs.
// No dependencies; every other file of the block imports it.
package rrtr_pkg;

	localparam int ACT_W = 2;
	localparam int TID_W = 6;
	localparam int CNT_W = 7;

	// Thread numbers reachable through the 6-bit thread_id port.
	localparam int ID_SPACE = 1 << TID_W;

	localparam int DEF_MAX_THREADS = 64;

	localparam logic [ACT_W-1:0] ACT_ADMIT  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_PICK   = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic capture;   // accept beat: latch item, issue link reads and first writes
		logic finish;    // finishing cycle: finish links, update ring, load result
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_blocked;   // result register full and not being taken
	} dp_sts_t;

endpackage

FILE: hw/rtl/rrtr_ctrl.sv
// Controller for the round-robin thread ring: two-state sequencer.
// Depends on rrtr_pkg for state_t, ctrl_cmd_t and dp_sts_t.
module rrtr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rrtr_pkg::dp_sts_t  sts,
	output rrtr_pkg::ctrl_cmd_t cmd
);
	import rrtr_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.finish  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// hold until the result register can take the beat
				if (!sts.out_blocked) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/rrtr_datapath.sv
// Datapath for the round-robin thread ring: link memories, membership bits,
// head/tail/count registers and the result register. Depends on rrtr_pkg.
module rrtr_datapath #(
	parameter int MAX_THREADS = rrtr_pkg::DEF_MAX_THREADS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rrtr_pkg::ctrl_cmd_t         cmd,
	output rrtr_pkg::dp_sts_t           sts,
	input  logic [rrtr_pkg::ACT_W-1:0]  action,
	input  logic [rrtr_pkg::TID_W-1:0]  thread_id,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rrtr_pkg::TID_W-1:0]  chosen_thread,
	output logic                        chosen_valid,
	output logic                        ignored,
	output logic [rrtr_pkg::CNT_W-1:0]  thread_count
);
	import rrtr_pkg::*;

	localparam int NUM_IDS = (MAX_THREADS < ID_SPACE) ? MAX_THREADS : ID_SPACE;
	localparam int IW      = $clog2(NUM_IDS);
	localparam int CW      = $clog2(MAX_THREADS + 1);

	// link tables
	logic [IW-1:0] next_mem [NUM_IDS];
	logic [IW-1:0] prev_mem [NUM_IDS];

	logic [NUM_IDS-1:0] member_q;
	logic [IW-1:0]      head_q, tail_q;
	logic [CW-1:0]      cnt_q;

	// item held between the accept and finishing cycles
	logic [ACT_W-1:0] act_q;
	logic [IW-1:0]    tid_q;
	logic             ok_q, empty_q, single_q;
	logic [IW-1:0]    rd_next_q, rd_prev_q;

	logic [TID_W-1:0] res_thread_q;
	logic             res_cvalid_q, res_ign_q, out_valid_q;
	logic [CNT_W-1:0] res_cnt_q;

	logic [IW-1:0] tid_idx, rd_addr;
	logic          in_range, is_member, ring_empty, ring_full, ok_now;

	logic          nx_we, pv_we;
	logic [IW-1:0] nx_wa, nx_wd, pv_wa, pv_wd;

	logic [IW-1:0] head_d, tail_d;
	logic [CW-1:0] cnt_d;
	logic          cvalid_d, ign_d;

	assign tid_idx    = thread_id[IW-1:0];
	assign in_range   = (CNT_W'(thread_id) < CNT_W'(NUM_IDS));
	assign is_member  = in_range && member_q[tid_idx];
	assign ring_empty = (cnt_q == '0);
	assign ring_full  = (cnt_q == CW'(MAX_THREADS));
	assign rd_addr    = (action == ACT_PICK) ? head_q : tid_idx;

	always_comb begin
		case (action)
			ACT_ADMIT:  ok_now = in_range && !is_member && !ring_full;
			ACT_REMOVE: ok_now = is_member;
			ACT_PICK:   ok_now = !ring_empty;
			default:    ok_now = 1'b0;
		endcase
	end

	// write ports: first half of an admit on the accept beat, neighbor
	// links on the finishing cycle
	always_comb begin
		nx_we = 1'b0;
		nx_wa = '0;
		nx_wd = '0;
		pv_we = 1'b0;
		pv_wa = '0;
		pv_wd = '0;
		if (cmd.capture && action == ACT_ADMIT && ok_now) begin
			nx_we = 1'b1;
			nx_wa = tid_idx;
			nx_wd = ring_empty ? tid_idx : head_q;
			pv_we = 1'b1;
			pv_wa = tid_idx;
			pv_wd = ring_empty ? tid_idx : tail_q;
		end else if (cmd.finish && ok_q) begin
			case (act_q)
				ACT_ADMIT: begin
					if (!empty_q) begin
						nx_we = 1'b1;
						nx_wa = tail_q;
						nx_wd = tid_q;
						pv_we = 1'b1;
						pv_wa = head_q;
						pv_wd = tid_q;
					end
				end
				ACT_REMOVE: begin
					if (!single_q) begin
						nx_we = 1'b1;
						nx_wa = rd_prev_q;
						nx_wd = rd_next_q;
						pv_we = 1'b1;
						pv_wa = rd_next_q;
						pv_wd = rd_prev_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_wa] <= nx_wd;
		end
		if (pv_we) begin
			prev_mem[pv_wa] <= pv_wd;
		end
		if (cmd.capture) begin
			rd_next_q <= next_mem[rd_addr];
			rd_prev_q <= prev_mem[tid_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q    <= action;
			tid_q    <= tid_idx;
			ok_q     <= ok_now;
			empty_q  <= ring_empty;
			single_q <= (cnt_q == CW'(1));
		end
	end

	// ring update for the finishing cycle
	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		cnt_d    = cnt_q;
		cvalid_d = 1'b0;
		ign_d    = 1'b0;
		case (act_q)
			ACT_ADMIT: begin
				ign_d = !ok_q;
				if (ok_q) begin
					if (empty_q) begin
						head_d = tid_q;
					end
					tail_d = tid_q;
					cnt_d  = cnt_q + CW'(1);
				end
			end
			ACT_REMOVE: begin
				ign_d = !ok_q;
				if (ok_q) begin
					if (single_q) begin
						head_d = '0;
						tail_d = '0;
						cnt_d  = '0;
					end else begin
						if (tid_q == head_q) begin
							head_d = rd_next_q;
						end else if (tid_q == tail_q) begin
							tail_d = rd_prev_q;
						end
						cnt_d = cnt_q - CW'(1);
					end
				end
			end
			ACT_PICK: begin
				// the ring is circular, so the old head becomes the tail
				if (ok_q) begin
					head_d   = rd_next_q;
					tail_d   = head_q;
					cvalid_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			member_q    <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				head_q      <= head_d;
				tail_q      <= tail_d;
				cnt_q       <= cnt_d;
				out_valid_q <= 1'b1;
				if (ok_q && act_q == ACT_ADMIT) begin
					member_q[tid_q] <= 1'b1;
				end else if (ok_q && act_q == ACT_REMOVE) begin
					member_q[tid_q] <= 1'b0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_thread_q <= cvalid_d ? TID_W'(head_q) : '0;
			res_cvalid_q <= cvalid_d;
			res_ign_q    <= ign_d;
			res_cnt_q    <= CNT_W'(cnt_d);
		end
	end

	assign sts.out_blocked = out_valid_q && !out_ready;
	assign out_valid       = out_valid_q;
	assign chosen_thread   = res_thread_q;
	assign chosen_valid    = res_cvalid_q;
	assign ignored         = res_ign_q;
	assign thread_count    = res_cnt_q;

endmodule

FILE: hw/rtl/round_robin_thread_ring.sv
// Top level of the round-robin thread ring scheduler queue.
// Instantiates rrtr_ctrl and rrtr_datapath; depends on rrtr_pkg.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one beat per action:
//    action = admit, remove or pick next, with thread_id for admit/remove.
//  - Output channel (out_valid/out_ready) returns exactly one result beat
//    per input beat: chosen_thread, chosen_valid, ignored, thread_count.
//  - Each action has an accept cycle and a finishing cycle: the accept cycle
//    issues the link-table reads (and the new thread's own links for an
//    admit), the finishing cycle rewrites the neighbor links, since each link
//    table has one write port. A new action is accepted only once the last
//    has finished; the finishing cycle loads its result onto out_valid.
//  - Invalid admits (member, full ring, thread out of range) and removes of
//    non-members leave the ring untouched and return ignored = 1.
//  - Reset clears head, tail, count and all membership bits at once; the
//    link tables need no clearing and the block takes a beat right away.
//  - When the receiver stalls, the result register holds; the next action
//    is still accepted and waits in its finishing state until the result
//    register is drained.
module round_robin_thread_ring #(
	parameter int MAX_THREADS = rrtr_pkg::DEF_MAX_THREADS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [rrtr_pkg::ACT_W-1:0]  action,
	input  logic [rrtr_pkg::TID_W-1:0]  thread_id,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rrtr_pkg::TID_W-1:0]  chosen_thread,
	output logic                        chosen_valid,
	output logic                        ignored,
	output logic [rrtr_pkg::CNT_W-1:0]  thread_count
);
	import rrtr_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// sequencer: accept, then finish once the result register is free
	rrtr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// link tables, ring registers and the result register
	rrtr_datapath #(
		.MAX_THREADS (MAX_THREADS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.action        (action),
		.thread_id     (thread_id),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.chosen_thread (chosen_thread),
		.chosen_valid  (chosen_valid),
		.ignored       (ignored),
		.thread_count  (thread_count)
	);

endmodule

FILE: hw/rtl/rrtr_checker.sv
// Port-level checker for the round-robin thread ring, bound to the top.
// Depends on rrtr_pkg and on the top level's port names.
module rrtr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [rrtr_pkg::ACT_W-1:0]  action,
	input logic [rrtr_pkg::TID_W-1:0]  thread_id,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [rrtr_pkg::TID_W-1:0]  chosen_thread,
	input logic                        chosen_valid,
	input logic                        ignored,
	input logic [rrtr_pkg::CNT_W-1:0]  thread_count
);
	import rrtr_pkg::*;

	// one action at a time: no accept in the cycle after an accept
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted on consecutive cycles");

	// a pick never flags ignored
	a_pick_not_ign: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && chosen_valid) |-> !ignored)
		else $error("chosen_valid and ignored both set");

	// no thread reported unless one was chosen
	a_chosen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !chosen_valid) |-> (chosen_thread == '0))
		else $error("chosen_thread nonzero without chosen_valid");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(chosen_thread) &&
			$stable(chosen_valid) && $stable(ignored) && $stable(thread_count)))
		else $error("result changed while stalled");

	// the ring never holds more threads than there are thread numbers
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (thread_count <= CNT_W'(ID_SPACE)))
		else $error("thread_count beyond thread number space");

endmodule

bind round_robin_thread_ring rrtr_checker u_rrtr_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench for round_robin_thread_ring: admit, remove and pick-next beats
// are checked against a cycle-free model of the ring kept in the bench.
// Depends on rrtr_pkg and the round_robin_thread_ring RTL only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rrtr_pkg::*;

	localparam int RING_CAP = DEF_MAX_THREADS;
	// Code 3 is not an action; the block must answer it with a plain count.
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [TID_W-1:0] chosen;
		logic             chosen_ok;
		logic             rejected;
		logic [CNT_W-1:0] count;
	} ring_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [ACT_W-1:0] action = '0;
	logic [TID_W-1:0] thread_id = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [TID_W-1:0] chosen_thread;
	logic             chosen_valid;
	logic             ignored;
	logic [CNT_W-1:0] thread_count;

	round_robin_thread_ring #(
		.MAX_THREADS(RING_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.thread_id(thread_id),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.chosen_thread(chosen_thread),
		.chosen_valid(chosen_valid),
		.ignored(ignored),
		.thread_count(thread_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// ------------------------------------------------------------------
	// Ring model: link tables, membership, head, tail and size.
	// ------------------------------------------------------------------
	logic [TID_W-1:0] ring_next [RING_CAP];
	logic [TID_W-1:0] ring_prev [RING_CAP];
	logic             ring_member [RING_CAP];
	logic [TID_W-1:0] ring_head = '0;
	logic [TID_W-1:0] ring_tail = '0;
	int               ring_size = 0;

	ring_result_t pending_results [$];
	int           mismatch_count = 0;

	// Sender pacing: bursts of random length, gaps between them unless eager.
	int burst_left = 0;
	bit sender_eager = 1'b0;

	// Long receiver hold-off asked by a test; the receiver counts it down itself.
	int receiver_hold_request = 0;

	initial begin
		for (int i = 0; i < RING_CAP; i++) begin
			ring_next[i] = '0;
			ring_prev[i] = '0;
			ring_member[i] = 1'b0;
		end
	end

	// Apply one action to the ring model and return the result the block owes.
	function automatic ring_result_t predict_action(input logic [ACT_W-1:0] act,
			input logic [TID_W-1:0] tid);
		ring_result_t r;
		logic [TID_W-1:0] nx, pv;
		r = '0;
		case (act)
			ACT_ADMIT: begin
				if (int'(tid) >= RING_CAP || ring_member[tid] || ring_size >= RING_CAP) begin
					r.rejected = 1'b1;
				end else begin
					if (ring_size == 0) begin
						ring_next[tid] = tid;
						ring_prev[tid] = tid;
						ring_head = tid;
					end else begin
						ring_next[tid] = ring_head;
						ring_prev[tid] = ring_tail;
						ring_prev[ring_head] = tid;
						ring_next[ring_tail] = tid;
					end
					ring_tail = tid;
					ring_member[tid] = 1'b1;
					ring_size++;
				end
			end
			ACT_REMOVE: begin
				if (int'(tid) >= RING_CAP || !ring_member[tid]) begin
					r.rejected = 1'b1;
				end else begin
					ring_member[tid] = 1'b0;
					if (ring_size <= 1) begin
						// Last thread leaves: head and tail fall back to zero.
						ring_head = '0;
						ring_tail = '0;
						ring_size = 0;
					end else begin
						nx = ring_next[tid];
						pv = ring_prev[tid];
						ring_prev[nx] = pv;
						ring_next[pv] = nx;
						if (tid == ring_head)
							ring_head = nx;
						else if (tid == ring_tail)
							ring_tail = pv;
						ring_size--;
					end
				end
			end
			ACT_PICK: begin
				// Rotate: old head becomes tail and is the thread chosen.
				if (ring_size != 0) begin
					ring_head = ring_next[ring_head];
					ring_tail = ring_prev[ring_head];
					r.chosen = ring_tail;
					r.chosen_ok = 1'b1;
				end
			end
			default: ;
		endcase
		r.count = CNT_W'(ring_size);
		return r;
	endfunction

	function automatic logic [TID_W-1:0] any_member();
		int start;
		start = $urandom_range(RING_CAP - 1);
		for (int i = 0; i < RING_CAP; i++)
			if (ring_member[(start + i) % RING_CAP])
				return TID_W'((start + i) % RING_CAP);
		return TID_W'(start);
	endfunction

	function automatic logic [TID_W-1:0] any_outsider();
		int start;
		start = $urandom_range(RING_CAP - 1);
		for (int i = 0; i < RING_CAP; i++)
			if (!ring_member[(start + i) % RING_CAP])
				return TID_W'((start + i) % RING_CAP);
		return TID_W'(start);
	endfunction

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Offer one beat and hold it until accepted, then record its expected result.
	// Valid is only dropped at the start of a gap, so back-to-back beats keep it high.
	task automatic send_beat(input logic [ACT_W-1:0] act, input logic [TID_W-1:0] tid);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = sender_eager ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		action <= act;
		thread_id <= tid;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_action(act, tid));
	endtask

	// Drop valid and hold off until every outstanding result has come back.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// Output side: check each result beat, then choose next cycle's ready.
	// ------------------------------------------------------------------
	int          receiver_hold_left = 0;
	int unsigned receiver_phase = 0;
	logic [4:0]  stall_pattern = 5'b10110;

	always @(posedge clk) begin
		ring_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result beat with nothing outstanding");
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					if (chosen_thread !== want.chosen) begin
						$error("chosen_thread: expected %0d, got %0d", want.chosen, chosen_thread);
						mismatch_count++;
					end
					if (chosen_valid !== want.chosen_ok) begin
						$error("chosen_valid: expected %0b, got %0b", want.chosen_ok, chosen_valid);
						mismatch_count++;
					end
					if (ignored !== want.rejected) begin
						$error("ignored: expected %0b, got %0b", want.rejected, ignored);
						mismatch_count++;
					end
					if (thread_count !== want.count) begin
						$error("thread_count: expected %0d, got %0d", want.count, thread_count);
						mismatch_count++;
					end
				end
			end

			if (receiver_hold_request != 0) begin
				receiver_hold_left = receiver_hold_request;
				receiver_hold_request = 0;
			end
			if (receiver_hold_left > 0) begin
				receiver_hold_left--;
				out_ready <= 1'b0;
			end else begin
				// Rotate through stall styles, including a stall-free one.
				receiver_phase++;
				case (receiver_phase[7:6])
					2'd0: out_ready <= 1'b1;
					2'd1: out_ready <= ($urandom_range(99) < 70);
					2'd2: begin
						out_ready <= stall_pattern[0];
						stall_pattern <= {stall_pattern[0], stall_pattern[4:1]};
					end
					default: out_ready <= ($urandom_range(99) < 30);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Empty-ring corners, extreme ids, duplicate admit, removes at head, tail,
	// middle and of the last member, and the unused action code.
	task automatic test_directed_cases();
		send_beat(ACT_PICK, 6'd0);
		send_beat(ACT_REMOVE, 6'd5);
		send_beat(ACT_UNUSED, 6'd0);
		send_beat(ACT_ADMIT, 6'd0);
		send_beat(ACT_ADMIT, 6'd63);
		send_beat(ACT_ADMIT, 6'd21);
		send_beat(ACT_ADMIT, 6'd42);
		send_beat(ACT_ADMIT, 6'd10);
		send_beat(ACT_ADMIT, 6'd63);
		send_beat(ACT_PICK, 6'd63);
		send_beat(ACT_PICK, 6'd0);
		send_beat(ACT_REMOVE, ring_head);
		send_beat(ACT_REMOVE, ring_tail);
		send_beat(ACT_REMOVE, ring_next[ring_head]);
		send_beat(ACT_PICK, 6'd21);
		send_beat(ACT_REMOVE, ring_head);
		send_beat(ACT_REMOVE, ring_head);
		send_beat(ACT_REMOVE, 6'd63);
		send_beat(ACT_PICK, 6'd0);
		send_beat(ACT_UNUSED, 6'd63);
		send_beat(ACT_ADMIT, 6'd33);
		send_beat(ACT_PICK, 6'd0);
		send_beat(ACT_PICK, 6'd0);
		send_beat(ACT_REMOVE, 6'd33);
		wait_for_results();
	endtask

	// Fill every slot in shuffled order, then admit into the full ring.
	task automatic test_full_ring();
		logic [TID_W-1:0] order [RING_CAP];
		logic [TID_W-1:0] swap;
		int j;
		for (int i = 0; i < RING_CAP; i++)
			order[i] = TID_W'(i);
		for (int i = RING_CAP - 1; i > 0; i--) begin
			j = $urandom_range(i);
			swap = order[i];
			order[i] = order[j];
			order[j] = swap;
		end
		sender_eager = 1'b1;
		for (int i = 0; i < RING_CAP; i++)
			send_beat(ACT_ADMIT, order[i]);
		send_beat(ACT_ADMIT, TID_W'($urandom));
		send_beat(ACT_PICK, 6'd0);
		send_beat(ACT_UNUSED, 6'd0);
		send_beat(ACT_REMOVE, ring_tail);
		send_beat(ACT_ADMIT, any_outsider());
		send_beat(ACT_ADMIT, any_outsider());
		sender_eager = 1'b0;
		wait_for_results();
	endtask

	// Hold the receiver off for a long stretch while beats keep coming, so the
	// block fills and drops in_ready; then pause until all results are back.
	task automatic test_output_backpressure();
		sender_eager = 1'b1;
		receiver_hold_request = 300;
		for (int i = 0; i < 20; i++) begin
			if (i % 3 == 0)
				send_beat(ACT_PICK, TID_W'($urandom));
			else if (i % 3 == 1)
				send_beat(ACT_ADMIT, any_outsider());
			else
				send_beat(ACT_REMOVE, any_member());
		end
		sender_eager = 1'b0;
		wait_for_results();
	endtask

	// Mostly legal traffic with a drifting grow/shrink bias so the ring swings
	// between empty and full; a small share is rejected or unused-code noise.
	task automatic test_random_traffic(input int n_items);
		int grow_bias;
		int roll;
		grow_bias = 50;
		for (int i = 0; i < n_items; i++) begin
			if (i % 120 == 0) begin
				case ($urandom_range(4))
					0: grow_bias = 15;
					1: grow_bias = 35;
					2: grow_bias = 50;
					3: grow_bias = 70;
					default: grow_bias = 90;
				endcase
				sender_eager = ($urandom_range(3) == 0);
			end
			if (i % 250 == 249)
				wait_for_results();
			if ($urandom_range(99) < 8) begin
				case ($urandom_range(3))
					0: send_beat(ACT_ADMIT, (ring_size != 0) ? any_member() : TID_W'($urandom));
					1: send_beat(ACT_REMOVE, (ring_size != RING_CAP) ? any_outsider()
							: TID_W'($urandom));
					2: send_beat(ACT_UNUSED, TID_W'($urandom));
					default: send_beat(ACT_REMOVE, TID_W'($urandom));
				endcase
			end else begin
				roll = $urandom_range(99);
				if (roll < grow_bias)
					send_beat(ACT_ADMIT, (ring_size != RING_CAP) ? any_outsider()
							: TID_W'($urandom));
				else if (roll < grow_bias + (100 - grow_bias) / 2)
					send_beat(ACT_REMOVE, (ring_size != 0) ? any_member() : TID_W'($urandom));
				else
					send_beat(ACT_PICK, TID_W'($urandom));
			end
		end
		sender_eager = 1'b0;
		wait_for_results();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_full_ring();
		test_output_backpressure();
		test_random_traffic(1000);

		// Let any stray result beat surface before the verdict.
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/rrtr_pkg.sv
hw/rtl/rrtr_ctrl.sv
hw/rtl/rrtr_datapath.sv
hw/rtl/round_robin_thread_ring.sv
hw/rtl/rrtr_checker.sv
tb/testbench.sv
